@@ rtl/cwm_pkg.sv @@
// ----------------------------------------------------------------------------
// cwm_pkg - shared types and constants of the convolution window MAC unit
// Store dimensions, field widths, codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cwm_pkg;

   // store dimensions
   localparam int MAX_WIDTH    = 32;
   localparam int MAX_HEIGHT   = 32;
   localparam int CHANNELS     = 8;
   localparam int MAX_KERNEL   = 7;
   localparam int OUT_CHANNELS = 16;

   localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
   localparam int WGT_DEPTH = MAX_KERNEL * MAX_KERNEL * CHANNELS * OUT_CHANNELS;
   localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
   localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int OC_AW     = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;

   // word fields
   localparam int FUNC_W   = 2;
   localparam int COL_W    = 5;
   localparam int ROW_W    = 5;
   localparam int ICH_W    = 3;
   localparam int OCH_W    = 4;
   localparam int TAP_W    = 3;
   localparam int SAMPLE_W = 16;
   localparam int BIAS_W   = 32;
   localparam int RESULT_W = 32;

   // configuration
   localparam int MAP_W      = 6;
   localparam int KCFG_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   localparam logic [MAP_W-1:0]  RST_MAP_WIDTH  = 6'd32;
   localparam logic [MAP_W-1:0]  RST_MAP_HEIGHT = 6'd32;
   localparam logic [KCFG_W-1:0] RST_KERNEL     = 3'd3;
   localparam logic [KCFG_W-1:0] RST_STEP       = 3'd1;
   localparam logic [KCFG_W-1:0] RST_MARGIN     = 3'd0;

   // datapath widths: window position, product, accumulator
   localparam int POS_W  = COL_W + KCFG_W + 2;
   localparam int PROD_W = 2 * SAMPLE_W;
   localparam int ACC_W  = 48;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PIXEL   = 2'd0,
      FUNC_WEIGHT  = 2'd1,
      FUNC_BIAS    = 2'd2,
      FUNC_COMPUTE = 2'd3
   } cwm_func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAP_WIDTH     = 3'd0,
      REG_MAP_HEIGHT    = 3'd1,
      REG_KERNEL_WIDTH  = 3'd2,
      REG_KERNEL_HEIGHT = 3'd3,
      REG_STEP_COLS     = 3'd4,
      REG_STEP_ROWS     = 3'd5,
      REG_MARGIN_COLS   = 3'd6,
      REG_MARGIN_ROWS   = 3'd7
   } cwm_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } cwm_state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]          func;
      logic [COL_W-1:0]           col;
      logic [ROW_W-1:0]           row;
      logic [ICH_W-1:0]           in_chan;
      logic [OCH_W-1:0]           out_chan;
      logic [TAP_W-1:0]           tap_col;
      logic [TAP_W-1:0]           tap_row;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [BIAS_W-1:0]   bias_value;
   } cwm_item_type;

   typedef struct packed {
      logic write_item;   // store write of the accepted word
      logic start;        // compute word accepted: load window origin and bias
      logic issue;        // issue one tap into the MAC pipe
      logic emit;         // load the result register
   } cwm_cmd_type;

   typedef struct packed {
      logic empty_job;    // compute word with no taps or a bad channel
      logic last_tap;     // tap counters sit on the final tap
      logic pipe_busy;    // products still in flight
      logic slot_free;    // result register can take a new word
   } cwm_status_type;

endpackage

`default_nettype wire

@@ rtl/cwm_if.sv @@
// ----------------------------------------------------------------------------
// cwm_req_if / cwm_rsp_if - valid/ready channels of the MAC unit
// Request channel carries one item word, response channel one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwm_req_if import cwm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [FUNC_W-1:0]          func;
   logic [COL_W-1:0]           col;
   logic [ROW_W-1:0]           row;
   logic [ICH_W-1:0]           in_chan;
   logic [OCH_W-1:0]           out_chan;
   logic [TAP_W-1:0]           tap_col;
   logic [TAP_W-1:0]           tap_row;
   logic signed [SAMPLE_W-1:0] sample;
   logic signed [BIAS_W-1:0]   bias_value;

   modport source (output valid, func, col, row, in_chan, out_chan, tap_col, tap_row,
                   sample, bias_value, input ready);
   modport sink   (input valid, func, col, row, in_chan, out_chan, tap_col, tap_row,
                   sample, bias_value, output ready);
endinterface

interface cwm_rsp_if import cwm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

`default_nettype wire

@@ rtl/cwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cwm_ctrl - sequencer of the convolution window MAC unit
// Takes words, steps the datapath through the taps and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cwm_ctrl import cwm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [FUNC_W-1:0] req_func,
   output logic                   req_ready,
   input  wire cwm_status_type    status,
   output cwm_cmd_type            cmd
);

   cwm_state_type state_ff, state_in;
   logic          accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_COMPUTE)) begin
               state_in = status.empty_job ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.write_item = accept && (req_func != FUNC_COMPUTE);
            cmd.start      = accept && (req_func == FUNC_COMPUTE);
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
         end
         ST_FINISH: begin
            cmd.emit = status.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/cwm_datapath.sv @@
// ----------------------------------------------------------------------------
// cwm_datapath - stores, tap counters and MAC pipe of the MAC unit
// Pixel and weight memories, bias registers, config registers, one MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module cwm_datapath import cwm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cwm_cmd_type           cmd,
   input  wire cwm_item_type          item,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  rsp_ready,
   output cwm_status_type             status,
   output logic                       rsp_valid,
   output logic signed [RESULT_W-1:0] rsp_result
);

   // configuration registers
   logic [MAP_W-1:0]  map_width_ff, map_height_ff;
   logic [KCFG_W-1:0] kernel_width_ff, kernel_height_ff;
   logic [KCFG_W-1:0] step_cols_ff, step_rows_ff, margin_cols_ff, margin_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff     <= RST_MAP_WIDTH;
         map_height_ff    <= RST_MAP_HEIGHT;
         kernel_width_ff  <= RST_KERNEL;
         kernel_height_ff <= RST_KERNEL;
         step_cols_ff     <= RST_STEP;
         step_rows_ff     <= RST_STEP;
         margin_cols_ff   <= RST_MARGIN;
         margin_rows_ff   <= RST_MARGIN;
      end else if (csr_we) begin
         case (cwm_reg_type'(csr_index))
            REG_MAP_WIDTH:     map_width_ff     <= csr_data;
            REG_MAP_HEIGHT:    map_height_ff    <= csr_data;
            REG_KERNEL_WIDTH:  kernel_width_ff  <= csr_data[KCFG_W-1:0];
            REG_KERNEL_HEIGHT: kernel_height_ff <= csr_data[KCFG_W-1:0];
            REG_STEP_COLS:     step_cols_ff     <= csr_data[KCFG_W-1:0];
            REG_STEP_ROWS:     step_rows_ff     <= csr_data[KCFG_W-1:0];
            REG_MARGIN_COLS:   margin_cols_ff   <= csr_data[KCFG_W-1:0];
            REG_MARGIN_ROWS:   margin_rows_ff   <= csr_data[KCFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // effective sizes, clamped to the store dimensions
   logic [MAP_W-1:0]  w_eff, h_eff;
   logic [KCFG_W-1:0] kw_eff, kh_eff;

   assign w_eff  = (int'(map_width_ff) > MAX_WIDTH) ? MAP_W'(MAX_WIDTH) : map_width_ff;
   assign h_eff  = (int'(map_height_ff) > MAX_HEIGHT) ? MAP_W'(MAX_HEIGHT) : map_height_ff;
   assign kw_eff = (int'(kernel_width_ff) > MAX_KERNEL) ? KCFG_W'(MAX_KERNEL)
                                                         : kernel_width_ff;
   assign kh_eff = (int'(kernel_height_ff) > MAX_KERNEL) ? KCFG_W'(MAX_KERNEL)
                                                          : kernel_height_ff;

   // store writes
   logic              is_pix, is_wgt, is_bias;
   logic              pix_we, wgt_we, bias_we, oc_ok;
   logic [PIX_AW-1:0] pix_wr_addr;
   logic [WGT_AW-1:0] wgt_wr_addr;

   assign is_pix  = item.func == FUNC_PIXEL;
   assign is_wgt  = item.func == FUNC_WEIGHT;
   assign is_bias = item.func == FUNC_BIAS;
   assign oc_ok   = int'(item.out_chan) < OUT_CHANNELS;

   assign pix_we  = cmd.write_item && is_pix && (int'(item.col) < MAX_WIDTH)
                    && (int'(item.row) < MAX_HEIGHT) && (int'(item.in_chan) < CHANNELS);
   assign wgt_we  = cmd.write_item && is_wgt && oc_ok && (int'(item.in_chan) < CHANNELS)
                    && (int'(item.tap_col) < MAX_KERNEL) && (int'(item.tap_row) < MAX_KERNEL);
   assign bias_we = cmd.write_item && is_bias && oc_ok;

   assign pix_wr_addr = PIX_AW'((int'(item.in_chan) * MAX_HEIGHT + int'(item.row))
                                * MAX_WIDTH + int'(item.col));
   assign wgt_wr_addr = WGT_AW'(((int'(item.out_chan) * CHANNELS + int'(item.in_chan))
                                 * MAX_KERNEL + int'(item.tap_row)) * MAX_KERNEL
                                + int'(item.tap_col));

   // bias registers, cleared at reset
   logic signed [BIAS_W-1:0] bias_ff [OUT_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OUT_CHANNELS; i++) begin
            bias_ff[i] <= '0;
         end
      end else if (bias_we) begin
         bias_ff[OC_AW'(item.out_chan)] <= item.bias_value;
      end
   end

   // job registers and tap counters
   logic signed [POS_W-1:0] x0_ff, x0_in, y0_ff, y0_in;
   logic [OCH_W-1:0]        oc_ff;
   logic [KCFG_W-1:0]       kx_ff, ky_ff;
   logic [CH_W-1:0]         c_ff;
   logic                    kx_last, ky_last, c_last;

   assign x0_in = POS_W'(item.col) * POS_W'(step_cols_ff) - POS_W'(margin_cols_ff);
   assign y0_in = POS_W'(item.row) * POS_W'(step_rows_ff) - POS_W'(margin_rows_ff);

   assign kx_last = kx_ff == kw_eff - KCFG_W'(1);
   assign ky_last = ky_ff == kh_eff - KCFG_W'(1);
   assign c_last  = c_ff == CH_W'(CHANNELS - 1);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         oc_ff <= item.out_chan;
         kx_ff <= '0;
         ky_ff <= '0;
         c_ff  <= '0;
      end else if (cmd.issue) begin
         if (!kx_last) begin
            kx_ff <= kx_ff + KCFG_W'(1);
         end else begin
            kx_ff <= '0;
            if (!ky_last) begin
               ky_ff <= ky_ff + KCFG_W'(1);
            end else begin
               ky_ff <= '0;
               c_ff  <= c_ff + CH_W'(1);
            end
         end
      end
   end

   // tap address and window bounds
   logic signed [POS_W-1:0] x_tap, y_tap;
   logic                    in_range;
   logic [PIX_AW-1:0]       pix_rd_addr;
   logic [WGT_AW-1:0]       wgt_rd_addr;

   assign x_tap    = x0_ff + POS_W'(kx_ff);
   assign y_tap    = y0_ff + POS_W'(ky_ff);
   assign in_range = !x_tap[POS_W-1] && !y_tap[POS_W-1]
                     && (x_tap[POS_W-2:0] < (POS_W-1)'(w_eff))
                     && (y_tap[POS_W-2:0] < (POS_W-1)'(h_eff));

   assign pix_rd_addr = PIX_AW'((int'(c_ff) * MAX_HEIGHT + int'(y_tap[POS_W-2:0]))
                                * MAX_WIDTH + int'(x_tap[POS_W-2:0]));
   assign wgt_rd_addr = WGT_AW'(((int'(oc_ff) * CHANNELS + int'(c_ff)) * MAX_KERNEL
                                 + int'(ky_ff)) * MAX_KERNEL + int'(kx_ff));

   // memories, registered read
   logic signed [SAMPLE_W-1:0] pixel_mem [PIX_DEPTH];
   logic signed [SAMPLE_W-1:0] weight_mem [WGT_DEPTH];
   logic signed [SAMPLE_W-1:0] pix_rd_ff, wgt_rd_ff;

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pixel_mem[pix_wr_addr] <= item.sample;
      end
      pix_rd_ff <= pixel_mem[pix_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         weight_mem[wgt_wr_addr] <= item.sample;
      end
      wgt_rd_ff <= weight_mem[wgt_rd_addr];
   end

   // MAC pipe: read -> multiply -> accumulate
   logic                       v1_ff, inr1_ff, v2_ff;
   logic signed [SAMPLE_W-1:0] pix_gated;
   logic signed [PROD_W-1:0]   prod_in, prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;

   assign pix_gated = inr1_ff ? pix_rd_ff : '0;
   assign prod_in   = wgt_rd_ff * pix_gated;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      inr1_ff <= in_range;
      prod_ff <= prod_in;
      if (cmd.start) begin
         acc_ff <= oc_ok ? {{(ACC_W-BIAS_W){bias_ff[OC_AW'(item.out_chan)][BIAS_W-1]}},
                            bias_ff[OC_AW'(item.out_chan)]}
                         : '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   // saturation and result register
   logic                       sat_hi, sat_lo;
   logic signed [RESULT_W-1:0] sat_value;
   logic                       rsp_valid_ff;
   logic signed [RESULT_W-1:0] result_ff;

   assign sat_hi    = !acc_ff[ACC_W-1] && (|acc_ff[ACC_W-2:RESULT_W-1]);
   assign sat_lo    = acc_ff[ACC_W-1] && !(&acc_ff[ACC_W-2:RESULT_W-1]);
   assign sat_value = sat_hi ? {1'b0, {(RESULT_W-1){1'b1}}}
                    : sat_lo ? {1'b1, {(RESULT_W-1){1'b0}}}
                    : acc_ff[RESULT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         result_ff <= sat_value;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   assign status.empty_job = !oc_ok || (kw_eff == '0) || (kh_eff == '0);
   assign status.last_tap  = kx_last && ky_last && c_last;
   assign status.pipe_busy = v1_ff || v2_ff;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

@@ rtl/conv2d_window_mac_unit.sv @@
// ----------------------------------------------------------------------------
// conv2d_window_mac_unit - 2D convolution engine with stride and zero padding
// Holds a feature map, filter weights and biases; a compute word returns
// bias + sum of weight * pixel over the window and all input channels,
// Q16.16 saturated to 32 bits.
// ----------------------------------------------------------------------------
//
//  port      dir  handshake      content
//  req_bus   in   valid/ready    func, col, row, in_chan, out_chan, tap_col,
//                                tap_row, sample (Q8.8), bias_value (Q16.16)
//  rsp_bus   out  valid/ready    result (Q16.16), one word per compute word
//  csr_*     in   csr_we only    csr_index selects register, csr_data value
//
//  Store writes (pixel, weight, bias) give no word back.
//  A compute word steps through all KW*KH*CHANNELS taps in turn:
//  one shared multiplier and one pixel/weight memory read per tap set the pace.
//  A compute word with no taps or a bad output channel skips the taps.
//  Reset is synchronous: config returns to its defaults and biases clear to zero;
//  pixel and weight memories keep whatever they hold.
//  A stalled rsp_bus holds the result register; new words are taken meanwhile
//  and a later compute waits at its end for the register to drain.
//
`default_nettype none

module conv2d_window_mac_unit import cwm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   cwm_req_if.sink                    req_bus,
   cwm_rsp_if.source                  rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cwm_cmd_type    cmd;
   cwm_status_type status;
   cwm_item_type   item;
   logic           req_ready;
   logic           rsp_valid;
   logic signed [RESULT_W-1:0] rsp_result;

   // pack the request word for the datapath
   assign item.func       = req_bus.func;
   assign item.col        = req_bus.col;
   assign item.row        = req_bus.row;
   assign item.in_chan    = req_bus.in_chan;
   assign item.out_chan   = req_bus.out_chan;
   assign item.tap_col    = req_bus.tap_col;
   assign item.tap_row    = req_bus.tap_row;
   assign item.sample     = req_bus.sample;
   assign item.bias_value = req_bus.bias_value;

   cwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cwm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .item       (item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_ready  (rsp_bus.ready),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign req_bus.ready  = req_ready;
   assign rsp_bus.valid  = rsp_valid;
   assign rsp_bus.result = rsp_result;

endmodule

`default_nettype wire

@@ sim/conv2d_window_mac_unit_tb.sv @@
// ----------------------------------------------------------------------------
// conv2d_window_mac_unit_tb - self-checking bench of the convolution MAC unit
// Preloads a small corner of the pixel and weight stores, walks a short table
// of corner cases, then sends random store writes and compute words under
// several idling patterns. Only compute words whose window stays on written
// entries are sent. Each result word is compared against a window predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_window_mac_unit_tb;
   import cwm_pkg::*;

   localparam int CLK_HALF          = 10;
   localparam int RESET_CYCLES      = 6;
   localparam int SETTLE_CYCLES     = 16;          // lets the last store write settle
   localparam int TAIL_CYCLES       = 420;         // covers the longest compute
   localparam int TIMEOUT           = 20_000_000;  // in time units, stops a hung run
   localparam int RAND_SEGMENTS     = 8;
   localparam int WORDS_PER_SEGMENT = 24;
   localparam int MAX_REPORTS       = 10;
   localparam int PRE_MAP           = 4;   // preloaded pixel corner, columns and rows
   localparam int PRE_OCS           = 2;   // output channels with preloaded weights
   localparam int PRE_TAPS          = 2;   // preloaded square of filter taps

   typedef enum bit {ROW_WORD, ROW_CSR} row_kind_type;

   // one line of the directed table: either a register write or a request word
   typedef struct {
      row_kind_type          kind;
      cwm_reg_type           reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      cwm_item_type          word;
      bit                    has_exp;   // expected result typed in by hand
      logic [RESULT_W-1:0]   exp_val;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   cwm_req_if req_bus ();
   cwm_rsp_if rsp_bus ();

   conv2d_window_mac_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // bench copy of the stores and the register file
   logic signed [SAMPLE_W-1:0] pixel_mem  [PIX_DEPTH];
   logic signed [SAMPLE_W-1:0] weight_mem [WGT_DEPTH];
   logic signed [BIAS_W-1:0]   bias_mem   [OUT_CHANNELS];
   bit                         pix_set    [PIX_DEPTH];
   bit                         wgt_set    [WGT_DEPTH];

   logic [MAP_W-1:0]  cfg_map_w, cfg_map_h;
   logic [KCFG_W-1:0] cfg_kw, cfg_kh;
   logic [KCFG_W-1:0] cfg_step_c, cfg_step_r;
   logic [KCFG_W-1:0] cfg_margin_c, cfg_margin_r;

   // results of accepted compute words, oldest first
   logic [RESULT_W-1:0] pending_results [$];
   logic [RESULT_W-1:0] rx_expected;

   dir_row_type directed_rows [$];

   int bad_words;
   int gap_pct;     // chance in 100 that the sender idles a cycle
   int stall_pct;   // chance in 100 that the receiver stalls a cycle

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   initial begin
      #(TIMEOUT);
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // bias + sum over channels and taps of weight * pixel, saturated to 32 bits
   function automatic logic [RESULT_W-1:0] conv_window_sum(cwm_item_type word);
      longint acc;
      int     w_lim, h_lim, kw, kh, x0, y0, x, y, oc, wv, pv;
      w_lim = (cfg_map_w > MAX_WIDTH)  ? MAX_WIDTH  : int'(cfg_map_w);
      h_lim = (cfg_map_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_map_h);
      kw    = (cfg_kw > MAX_KERNEL) ? MAX_KERNEL : int'(cfg_kw);
      kh    = (cfg_kh > MAX_KERNEL) ? MAX_KERNEL : int'(cfg_kh);
      x0    = int'(word.col) * int'(cfg_step_c) - int'(cfg_margin_c);
      y0    = int'(word.row) * int'(cfg_step_r) - int'(cfg_margin_r);
      oc    = int'(word.out_chan);
      acc   = longint'(bias_mem[oc]);
      for (int c = 0; c < CHANNELS; c++) begin
         for (int ky = 0; ky < kh; ky++) begin
            for (int kx = 0; kx < kw; kx++) begin
               x  = x0 + kx;
               y  = y0 + ky;
               wv = int'(weight_mem[((oc * CHANNELS + c) * MAX_KERNEL + ky) * MAX_KERNEL + kx]);
               // padding: anything off the active map reads as zero
               if (x < 0 || y < 0 || x >= w_lim || y >= h_lim)
                  pv = 0;
               else
                  pv = int'(pixel_mem[(c * MAX_HEIGHT + y) * MAX_WIDTH + x]);
               acc += longint'(wv) * longint'(pv);
            end
         end
      end
      if (acc > longint'(32'sh7FFF_FFFF))
         acc = longint'(32'sh7FFF_FFFF);
      if (acc < longint'(32'sh8000_0000))
         acc = longint'(32'sh8000_0000);
      return acc[RESULT_W-1:0];
   endfunction

   // true when every weight and every on-map pixel of the window was written
   function automatic bit window_known(cwm_item_type word);
      int w_lim, h_lim, kw, kh, x0, y0, x, y, oc;
      bit ok;
      w_lim = (cfg_map_w > MAX_WIDTH)  ? MAX_WIDTH  : int'(cfg_map_w);
      h_lim = (cfg_map_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_map_h);
      kw    = (cfg_kw > MAX_KERNEL) ? MAX_KERNEL : int'(cfg_kw);
      kh    = (cfg_kh > MAX_KERNEL) ? MAX_KERNEL : int'(cfg_kh);
      x0    = int'(word.col) * int'(cfg_step_c) - int'(cfg_margin_c);
      y0    = int'(word.row) * int'(cfg_step_r) - int'(cfg_margin_r);
      oc    = int'(word.out_chan);
      ok    = 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
         for (int ky = 0; ky < kh; ky++) begin
            for (int kx = 0; kx < kw; kx++) begin
               x = x0 + kx;
               y = y0 + ky;
               if (!wgt_set[((oc * CHANNELS + c) * MAX_KERNEL + ky) * MAX_KERNEL + kx])
                  ok = 1'b0;
               if (x >= 0 && y >= 0 && x < w_lim && y < h_lim
                   && !pix_set[(c * MAX_HEIGHT + y) * MAX_WIDTH + x])
                  ok = 1'b0;
            end
         end
      end
      return ok;
   endfunction

   // store writes; weight taps past the kernel store are dropped
   task automatic store_write(cwm_item_type word);
      int pix_idx, wgt_idx;
      pix_idx = (int'(word.in_chan) * MAX_HEIGHT + int'(word.row)) * MAX_WIDTH
                + int'(word.col);
      wgt_idx = ((int'(word.out_chan) * CHANNELS + int'(word.in_chan)) * MAX_KERNEL
                 + int'(word.tap_row)) * MAX_KERNEL + int'(word.tap_col);
      case (word.func)
         FUNC_PIXEL: begin
            pixel_mem[pix_idx] = word.sample;
            pix_set[pix_idx]   = 1'b1;
         end
         FUNC_WEIGHT: begin
            if (word.tap_col < MAX_KERNEL && word.tap_row < MAX_KERNEL) begin
               weight_mem[wgt_idx] = word.sample;
               wgt_set[wgt_idx]    = 1'b1;
            end
         end
         FUNC_BIAS: begin
            bias_mem[word.out_chan] = word.bias_value;
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic [SAMPLE_W-1:0] small_sample();
      int v;
      v = int'($urandom_range(2047)) - 1024;
      return v[SAMPLE_W-1:0];
   endfunction

   // random word: all fields noise, then func and the fields it uses shaped
   function automatic cwm_item_type random_word();
      cwm_item_type w;
      int           roll, b;
      // positions and output channels lean toward the preloaded corner
      w.col        = ($urandom_range(3) != 0) ? 5'($urandom_range(PRE_MAP - 1))
                                              : 5'($urandom_range(31));
      w.row        = ($urandom_range(3) != 0) ? 5'($urandom_range(PRE_MAP - 1))
                                              : 5'($urandom_range(31));
      w.in_chan    = 3'($urandom_range(7));
      w.out_chan   = ($urandom_range(3) != 0) ? 4'($urandom_range(PRE_OCS - 1))
                                              : 4'($urandom_range(15));
      w.tap_col    = 3'($urandom_range(MAX_KERNEL - 1));
      w.tap_row    = 3'($urandom_range(MAX_KERNEL - 1));
      // mostly small values so sums do not always pin at the rails
      w.sample     = ($urandom_range(7) == 0) ? 16'($urandom) : small_sample();
      b            = int'($urandom_range(1 << 20)) - (1 << 19);
      w.bias_value = ($urandom_range(3) == 0) ? 32'($urandom) : 32'(b);
      roll = $urandom_range(99);
      if (roll < 35)
         w.func = FUNC_PIXEL;
      else if (roll < 60)
         w.func = FUNC_WEIGHT;
      else if (roll < 70)
         w.func = FUNC_BIAS;
      else
         w.func = FUNC_COMPUTE;
      // now and then a tap past the store, which the block drops
      if ($urandom_range(7) == 0)
         w.tap_col = 3'd7;
      if ($urandom_range(7) == 0)
         w.tap_row = 3'd7;
      return w;
   endfunction

   // register value with the extremes weighted up; spare data bits are noise
   function automatic logic [CSR_DATA_W-1:0] pick_reg_value(cwm_reg_type idx);
      int                    roll;
      logic [CSR_DATA_W-1:0] v;
      roll = $urandom_range(3);
      case (idx)
         REG_MAP_WIDTH, REG_MAP_HEIGHT: begin
            if (roll == 0)
               v = 6'($urandom_range(1));
            else if (roll == 1)
               v = $urandom_range(1) ? 6'd32 : 6'd63;
            else
               v = 6'($urandom_range(PRE_MAP, 1));
         end
         REG_KERNEL_WIDTH: begin
            if (roll == 0)
               v = 6'($urandom_range(1));
            else if (roll == 1)
               v = 6'd7;
            else
               v = 6'($urandom_range(PRE_TAPS, 1));
         end
         REG_KERNEL_HEIGHT: begin
            if (roll == 0)
               v = 6'($urandom_range(1));
            else
               v = 6'($urandom_range(PRE_TAPS, 1));
         end
         REG_STEP_COLS, REG_STEP_ROWS: begin
            if (roll == 0)
               v = 6'($urandom_range(1));
            else if (roll == 1)
               v = 6'd7;
            else
               v = 6'($urandom_range(3, 1));
         end
         default: begin
            if (roll == 0)
               v = 6'd0;
            else if (roll == 1)
               v = 6'($urandom_range(7, 6));
            else
               v = 6'($urandom_range(3));
         end
      endcase
      if (idx != REG_MAP_WIDTH && idx != REG_MAP_HEIGHT)
         v[CSR_DATA_W-1:KCFG_W] = 3'($urandom_range(7));
      return v;
   endfunction

   function automatic dir_row_type csr_row(cwm_reg_type idx, logic [CSR_DATA_W-1:0] val);
      dir_row_type r;
      r.kind    = ROW_CSR;
      r.reg_idx = idx;
      r.reg_val = val;
      r.word    = '0;
      r.has_exp = 1'b0;
      r.exp_val = '0;
      return r;
   endfunction

   function automatic dir_row_type word_row(cwm_func_type func, logic [COL_W-1:0] col,
                                            logic [ROW_W-1:0] row, logic [ICH_W-1:0] ic,
                                            logic [OCH_W-1:0] oc, logic [TAP_W-1:0] tc,
                                            logic [TAP_W-1:0] tr, logic [SAMPLE_W-1:0] sample,
                                            logic [BIAS_W-1:0] bias, bit has_exp,
                                            logic [RESULT_W-1:0] exp_val);
      dir_row_type r;
      r.kind            = ROW_WORD;
      r.reg_idx         = REG_MAP_WIDTH;
      r.reg_val         = '0;
      r.word.func       = func;
      r.word.col        = col;
      r.word.row        = row;
      r.word.in_chan    = ic;
      r.word.out_chan   = oc;
      r.word.tap_col    = tc;
      r.word.tap_row    = tr;
      r.word.sample     = sample;
      r.word.bias_value = bias;
      r.has_exp         = has_exp;
      r.exp_val         = exp_val;
      return r;
   endfunction

   task automatic add_row(dir_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endtask

   // present one word, hold it until the unit takes it, then update the copy
   task automatic send_word(cwm_item_type w, bit has_exp, logic [RESULT_W-1:0] exp_val);
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= w.func;
      req_bus.col        <= w.col;
      req_bus.row        <= w.row;
      req_bus.in_chan    <= w.in_chan;
      req_bus.out_chan   <= w.out_chan;
      req_bus.tap_col    <= w.tap_col;
      req_bus.tap_row    <= w.tap_row;
      req_bus.sample     <= w.sample;
      req_bus.bias_value <= w.bias_value;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (w.func == FUNC_COMPUTE)
         pending_results.insert(pending_results.size(),
                                has_exp ? exp_val : conv_window_sum(w));
      else
         store_write(w);
   endtask

   // quiet the request side and let every outstanding result come home
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write; a wait with csr_we low keeps it from toggling twice a step
   task automatic set_reg(cwm_reg_type idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_MAP_WIDTH:     cfg_map_w    = val[MAP_W-1:0];
         REG_MAP_HEIGHT:    cfg_map_h    = val[MAP_W-1:0];
         REG_KERNEL_WIDTH:  cfg_kw       = val[KCFG_W-1:0];
         REG_KERNEL_HEIGHT: cfg_kh       = val[KCFG_W-1:0];
         REG_STEP_COLS:     cfg_step_c   = val[KCFG_W-1:0];
         REG_STEP_ROWS:     cfg_step_r   = val[KCFG_W-1:0];
         REG_MARGIN_COLS:   cfg_margin_c = val[KCFG_W-1:0];
         REG_MARGIN_ROWS:   cfg_margin_r = val[KCFG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic [RESULT_W-1:0] want,
                                  logic [RESULT_W-1:0] got);
      if (bad_words < MAX_REPORTS)
         $display("mismatch at %0t: %s, expected %h, got %h", $realtime, what, want, got);
      bad_words++;
   endtask

   // ------------------------------------------------------------------------
   // result side: random stalls, compare each taken word with the oldest
   // expectation. ready is sampled at the edge before it is re-driven.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result word with nothing pending", 'x, rsp_bus.result);
         end else begin
            rx_expected = pending_results.pop_front();
            if (rsp_bus.result !== rx_expected)
               report_mismatch("result", rx_expected, rsp_bus.result);
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      cwm_item_type fill_word;
      cwm_item_type rand_word;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      req_bus.valid      = 1'b0;
      req_bus.func       = '0;
      req_bus.col        = '0;
      req_bus.row        = '0;
      req_bus.in_chan    = '0;
      req_bus.out_chan   = '0;
      req_bus.tap_col    = '0;
      req_bus.tap_row    = '0;
      req_bus.sample     = '0;
      req_bus.bias_value = '0;
      gap_pct            = 0;
      stall_pct          = 0;
      bad_words          = 0;

      // state after reset: register defaults, biases cleared
      cfg_map_w    = RST_MAP_WIDTH;
      cfg_map_h    = RST_MAP_HEIGHT;
      cfg_kw       = RST_KERNEL;
      cfg_kh       = RST_KERNEL;
      cfg_step_c   = RST_STEP;
      cfg_step_r   = RST_STEP;
      cfg_margin_c = RST_MARGIN;
      cfg_margin_r = RST_MARGIN;
      foreach (bias_mem[i])
         bias_mem[i] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Preload: pixel and weight memories are not cleared by reset. Fill the
      // top-left corner of every channel, a 2x2 tap square for the first output
      // channels and a full first tap row for output channel 0. Compute words
      // are only sent when their window stays on written entries.
      for (int ic = 0; ic < CHANNELS; ic++) begin
         for (int y = 0; y < PRE_MAP; y++) begin
            for (int x = 0; x < PRE_MAP; x++) begin
               fill_word         = random_word();
               fill_word.func    = FUNC_PIXEL;
               fill_word.col     = 5'(x);
               fill_word.row     = 5'(y);
               fill_word.in_chan = 3'(ic);
               fill_word.sample  = 16'($urandom);
               send_word(fill_word, 1'b0, '0);
            end
         end
      end
      for (int oc = 0; oc < PRE_OCS; oc++) begin
         for (int ic = 0; ic < CHANNELS; ic++) begin
            for (int ty = 0; ty < PRE_TAPS; ty++) begin
               for (int tx = 0; tx < MAX_KERNEL; tx++) begin
                  if (tx < PRE_TAPS || (oc == 0 && ty == 0)) begin
                     fill_word          = random_word();
                     fill_word.func     = FUNC_WEIGHT;
                     fill_word.out_chan = 4'(oc);
                     fill_word.in_chan  = 3'(ic);
                     fill_word.tap_row  = 3'(ty);
                     fill_word.tap_col  = 3'(tx);
                     fill_word.sample   = small_sample();
                     send_word(fill_word, 1'b0, '0);
                  end
               end
            end
         end
      end

      // Directed table. Typed expectations only where the answer is plain:
      // no taps, an all-padding window or an empty map leaves the bias alone.
      // no taps, biases still at their reset zeros
      add_row(csr_row(REG_KERNEL_WIDTH, 6'd0));
      add_row(word_row(FUNC_COMPUTE, 5'd0, 5'd0, 3'd0, 4'd0, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b1, 32'h0000_0000));
      add_row(word_row(FUNC_COMPUTE, 5'd31, 5'd31, 3'd7, 4'd15, 3'd7, 3'd7, 16'hFFFF,
                       32'hFFFF_FFFF, 1'b1, 32'h0000_0000));
      // bias extremes pass straight through
      add_row(word_row(FUNC_BIAS, 5'd0, 5'd0, 3'd0, 4'd3, 3'd0, 3'd0, 16'h0000,
                       32'h7FFF_FFFF, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd0, 5'd0, 3'd0, 4'd3, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b1, 32'h7FFF_FFFF));
      add_row(word_row(FUNC_BIAS, 5'd0, 5'd0, 3'd0, 4'd4, 3'd0, 3'd0, 16'h0000,
                       32'h8000_0000, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd0, 5'd0, 3'd0, 4'd4, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b1, 32'h8000_0000));
      add_row(word_row(FUNC_BIAS, 5'd0, 5'd0, 3'd0, 4'd5, 3'd0, 3'd0, 16'h0000,
                       32'hFFFF_0000, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd0, 5'd0, 3'd0, 4'd5, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b1, 32'hFFFF_0000));
      // 7x1 window on a 4x4 map, sums on top of the positive rail bias
      add_row(csr_row(REG_MAP_WIDTH, 6'd4));
      add_row(csr_row(REG_MAP_HEIGHT, 6'd4));
      add_row(csr_row(REG_KERNEL_WIDTH, 6'd7));
      add_row(csr_row(REG_KERNEL_HEIGHT, 6'd1));
      add_row(word_row(FUNC_BIAS, 5'd0, 5'd0, 3'd0, 4'd0, 3'd0, 3'd0, 16'h0000,
                       32'h7FFF_FFFF, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd0, 5'd0, 3'd0, 4'd0, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd2, 5'd3, 3'd0, 4'd0, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));
      // 2x2 window on top of the negative rail bias
      add_row(csr_row(REG_KERNEL_WIDTH, 6'd2));
      add_row(csr_row(REG_KERNEL_HEIGHT, 6'd2));
      add_row(word_row(FUNC_BIAS, 5'd0, 5'd0, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h8000_0000, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd0, 5'd0, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd3, 5'd3, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));
      // sample extremes at the map corners and the last weight tap
      add_row(word_row(FUNC_PIXEL, 5'd0, 5'd0, 3'd0, 4'd0, 3'd0, 3'd0, 16'h7FFF,
                       32'h0000_0000, 1'b0, '0));
      add_row(word_row(FUNC_PIXEL, 5'd3, 5'd3, 3'd7, 4'd0, 3'd0, 3'd0, 16'h8000,
                       32'h0000_0000, 1'b0, '0));
      add_row(word_row(FUNC_WEIGHT, 5'd0, 5'd0, 3'd7, 4'd1, 3'd1, 3'd1, 16'h8000,
                       32'h0000_0000, 1'b0, '0));
      add_row(word_row(FUNC_WEIGHT, 5'd0, 5'd0, 3'd7, 4'd15, 3'd6, 3'd6, 16'h8000,
                       32'h0000_0000, 1'b0, '0));
      // tap 7 is past the kernel store: dropped
      add_row(word_row(FUNC_WEIGHT, 5'd0, 5'd0, 3'd0, 4'd0, 3'd7, 3'd7, 16'h7FFF,
                       32'h0000_0000, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd0, 5'd0, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd2, 5'd2, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd0, 5'd0, 3'd0, 4'd0, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));
      // margin 7: the window at the origin is all padding
      add_row(csr_row(REG_MARGIN_COLS, 6'd7));
      add_row(csr_row(REG_MARGIN_ROWS, 6'd7));
      add_row(word_row(FUNC_COMPUTE, 5'd0, 5'd0, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b1, 32'h8000_0000));
      add_row(word_row(FUNC_COMPUTE, 5'd6, 5'd6, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));
      // zero and maximum stride
      add_row(csr_row(REG_STEP_COLS, 6'd0));
      add_row(csr_row(REG_STEP_ROWS, 6'd7));
      add_row(csr_row(REG_MARGIN_COLS, 6'd0));
      add_row(csr_row(REG_MARGIN_ROWS, 6'd0));
      add_row(word_row(FUNC_COMPUTE, 5'd31, 5'd0, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));
      add_row(word_row(FUNC_COMPUTE, 5'd31, 5'd3, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));
      // zero map width: every pixel reads zero, bias alone
      add_row(csr_row(REG_MAP_WIDTH, 6'd0));
      add_row(word_row(FUNC_COMPUTE, 5'd1, 5'd1, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b1, 32'h8000_0000));
      // map width past the store acts as the store width
      add_row(csr_row(REG_MAP_WIDTH, 6'd63));
      add_row(csr_row(REG_MAP_HEIGHT, 6'd1));
      add_row(word_row(FUNC_COMPUTE, 5'd0, 5'd0, 3'd0, 4'd1, 3'd0, 3'd0, 16'h0000,
                       32'h0000_0000, 1'b0, '0));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            set_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         end else begin
            send_word(directed_rows[i].word, directed_rows[i].has_exp,
                      directed_rows[i].exp_val);
         end
      end

      // Random part: fresh register settings per segment; two segments each
      // of no idling, sender gaps, receiver stalls, and both together.
      for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
         wait_idle();
         for (int r = 0; r < 8; r++)
            set_reg(cwm_reg_type'(r), pick_reg_value(cwm_reg_type'(r)));
         case (seg / 2)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 60; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 60; end
            default: begin gap_pct = 31; stall_pct = 31; end
         endcase
         for (int n = 0; n < WORDS_PER_SEGMENT; n++) begin
            rand_word = random_word();
            // redraw compute words that would touch unwritten entries
            while (rand_word.func == FUNC_COMPUTE && !window_known(rand_word))
               rand_word = random_word();
            send_word(rand_word, 1'b0, '0);
         end
      end

      // drain, then watch a while longer for stray result words
      gap_pct = 0;
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_words == 0 && pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
